@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the bounded fraction block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at each rising clock edge outside reset
`define BDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define BDF_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BDF_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDF_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

@@ hdl/bdf_pkg.sv @@
// ----------------------------------------------------------------------------
// bdf_pkg
// Types and constants for the bounded denominator fraction block.
// ----------------------------------------------------------------------------
package bdf_pkg;

    // fixed field widths
    localparam int WHOLE_W   = 32;
    localparam int FRAC_IN_W = 48;
    localparam int NUM_W     = 48;
    localparam int DEN_OUT_W = 16;
    localparam int CFG_W     = 16;
    localparam int DEN_RESET = 9999;

    // register indexes
    localparam logic [1:0] REG_MAX_DEN = 2'd0;
    localparam logic [1:0] REG_MODE    = 2'd1;
    localparam logic [1:0] REG_FORM    = 2'd2;

    // denominator modes
    localparam logic [1:0] MODE_ANY   = 2'd0;
    localparam logic [1:0] MODE_FIXED = 2'd1;

    // sign codes
    localparam logic [1:0] SIGN_ZERO = 2'd0;
    localparam logic [1:0] SIGN_POS  = 2'd1;
    localparam logic [1:0] SIGN_NEG  = 2'd2;

    // relation codes
    localparam logic [1:0] REL_EQ    = 2'd0;
    localparam logic [1:0] REL_BELOW = 2'd1;
    localparam logic [1:0] REL_ABOVE = 2'd2;

    typedef enum logic {ALU_MUL, ALU_REM} t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_sts;

endpackage

@@ hdl/bdf_in_if.sv @@
// ----------------------------------------------------------------------------
// bdf_in_if
// Request channel: sign, integer part and binary fraction of one value.
// ----------------------------------------------------------------------------
interface bdf_in_if;
    logic        valid;
    logic        ready;
    logic        negative;
    logic [31:0] whole_part;
    logic [47:0] fraction_bits;

    modport source (output valid, output negative, output whole_part,
                    output fraction_bits, input ready);
    modport sink   (input valid, input negative, input whole_part,
                    input fraction_bits, output ready);
endinterface

@@ hdl/bdf_out_if.sv @@
// ----------------------------------------------------------------------------
// bdf_out_if
// Result channel: sign, integer part, fraction and its relation to the value.
// ----------------------------------------------------------------------------
interface bdf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  sign_code;
    logic [31:0] integer_out;
    logic [47:0] numerator;
    logic [15:0] denominator;
    logic [1:0]  relation;

    modport source (output valid, output sign_code, output integer_out,
                    output numerator, output denominator, output relation,
                    input ready);
    modport sink   (input valid, input sign_code, input integer_out,
                    input numerator, input denominator, input relation,
                    output ready);
endinterface

@@ hdl/bdf_alu.sv @@
// ----------------------------------------------------------------------------
// bdf_alu
// Shared serial unit: shift-add multiply or restoring remainder, one bit
// of the DW-bit operand per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdf_alu import bdf_pkg::*; #(
    parameter int AW = 65,
    parameter int DW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_alu_ctl         i_ctl,
    input  logic [AW-1:0]    i_a,
    input  logic [DW-1:0]    i_b,
    output t_alu_sts         o_sts,
    output logic [AW+DW-1:0] o_prod,
    output logic [DW-1:0]    o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic             r_busy;
    logic             r_done;
    t_alu_op          r_op;
    logic [CW-1:0]    r_cnt;
    logic [AW+DW-1:0] r_acc;
    logic [AW+DW-1:0] r_mcand;
    logic [DW-1:0]    r_shreg;
    logic [DW-1:0]    r_div;
    logic [DW-1:0]    r_rem;
    logic [DW:0]      w_trial;

    // next partial remainder with the next dividend bit brought in
    assign w_trial = {r_rem, r_shreg[DW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= CW'(DW);
                r_op    <= i_ctl.op;
                r_acc   <= '0;
                r_mcand <= (AW+DW)'(i_a);
                r_rem   <= '0;
                r_div   <= i_b;
                r_shreg <= (i_ctl.op == ALU_MUL) ? i_b : i_a[DW-1:0];
            end else if (r_busy) begin
                case (r_op)
                    ALU_MUL: begin
                        if (r_shreg[0]) begin
                            r_acc <= r_acc + r_mcand;
                        end
                        r_mcand <= r_mcand << 1;
                        r_shreg <= r_shreg >> 1;
                    end
                    ALU_REM: begin
                        if (w_trial >= {1'b0, r_div}) begin
                            r_rem <= DW'(w_trial - {1'b0, r_div});
                        end else begin
                            r_rem <= w_trial[DW-1:0];
                        end
                        r_shreg <= r_shreg << 1;
                    end
                    default: begin
                        r_shreg <= r_shreg;
                    end
                endcase
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = r_acc;
    assign o_rem      = r_rem;

    `BDF_NEVER(a_start_busy, i_clk, i_rst_n, i_ctl.start && r_busy, "alu started while busy")
    `BDF_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy), "done without run")
    `BDF_NEVER(a_busy_and_done, i_clk, i_rst_n, r_busy && r_done, "busy and done together")

endmodule

@@ hdl/bounded_denominator_fraction.sv @@
// ----------------------------------------------------------------------------
// bounded_denominator_fraction
// Best fraction with bounded denominator for a signed fixed-point value:
// mediant search, fixed denominator, or best divisor of the maximum.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  i_in    | in  | valid / ready | negative, whole_part, fraction_bits
//  o_out   | out | valid / ready | sign_code, integer_out, numerator,
//          |     |               | denominator, relation
//  i_cfg_* | in  | write enable  | index, data
//
// One request at a time; ready only in idle. Mediant search: one tree step
// per cycle (up to max_denominator steps), then, unless a mediant is exact,
// a compare of the two bounding candidates by serial multiplies. Fixed mode:
// one serial multiply. Divisor mode: one serial remainder per candidate, plus
// a compare for each divisor after the first. Improper form adds a serial
// multiply. Reset is synchronous; a held result does not block intake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_denominator_fraction import bdf_pkg::*; #(
    parameter int FRAC_BITS = 48,
    parameter int DEN_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    bdf_in_if.sink           i_in,
    bdf_out_if.source        o_out
);

    localparam int F  = FRAC_BITS;
    localparam int D  = DEN_BITS;
    localparam int KW = D + 1;
    localparam int PW = F + D + 1;
    localparam int AW = (PW > WHOLE_W) ? PW : WHOLE_W;
    localparam int MW = AW + D;
    localparam int TOP_INT = (1 << D) - 1;
    localparam int RST_DEN = (DEN_RESET > TOP_INT) ? TOP_INT : DEN_RESET;
    localparam logic [CFG_W-1:0] TOP16 =
        (D >= CFG_W) ? {CFG_W{1'b1}} : CFG_W'(TOP_INT);
    localparam logic [PW:0] HALF = (PW+1)'(1) << (F - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_M0_STEP, S_CL_ERR, S_CL_MUL1, S_CL_WAIT1, S_CL_MUL2,
        S_CL_WAIT2, S_M1_MUL, S_M1_WAIT, S_M2_REM, S_M2_WAIT, S_M2_NEXT,
        S_REL, S_FOLD_MUL, S_FOLD_WAIT, S_DONE
    } t_state;

    // configuration
    logic [D-1:0] r_max;
    logic [1:0]   r_mode;
    logic         r_proper;

    // request
    t_state           r_state;
    logic             r_neg;
    logic             r_zero;
    logic [WHOLE_W-1:0] r_whole;
    logic [F-1:0]     r_fr;

    // tree bounds a/b and c/d with fr*b and fr*d
    logic [KW-1:0] r_a, r_b, r_c, r_d;
    logic [PW-1:0] r_pb, r_pd;

    // candidate 1 and best/candidate 2: numerator, denominator, fr*den
    logic [KW-1:0] r_n1, r_n2;
    logic [D-1:0]  r_k1, r_k2;
    logic [PW-1:0] r_p1, r_p2;
    logic [PW-1:0] r_e1, r_e2;
    logic [MW-1:0] r_prod1;

    // divisor scan
    logic [KW-1:0] r_i;
    logic [PW-1:0] r_pi;
    logic          r_have;

    logic [1:0]       r_rel;
    logic [NUM_W-1:0] r_num;

    // output register
    logic               r_ovalid;
    logic [1:0]         r_osign;
    logic [WHOLE_W-1:0] r_oint;
    logic [NUM_W-1:0]   r_onum;
    logic [DEN_OUT_W-1:0] r_oden;
    logic [1:0]         r_orel;

    // combinational
    logic [F+FRAC_IN_W-1:0] w_fr_ext;
    logic [F-1:0]       w_fr_in;
    logic [CFG_W-1:0]   w_cfg_den;
    logic [KW-1:0]      w_med_n, w_med_k;
    logic [PW-1:0]      w_med_p, w_med_lhs, w_lhs1, w_lhs2, w_rel_lhs;
    logic               w_in_loop;
    logic               w_take;
    logic               w_load;
    t_alu_ctl           w_alu_ctl;
    t_alu_sts           w_alu_sts;
    logic [AW-1:0]      w_alu_a;
    logic [D-1:0]       w_alu_b;
    logic [MW-1:0]      w_prod;
    logic [D-1:0]       w_rem;
    logic [MW+NUM_W-1:0] w_prod_ext;
    logic [D+DEN_OUT_W-1:0] w_den_ext;

    // round half up of p / 2^F
    function automatic logic [KW-1:0] f_round(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = {1'b0, p} + HALF;
        return s[F+KW-1:F];
    endfunction

    // fraction bits above F are dropped
    assign w_fr_ext = {{F{1'b0}}, i_in.fraction_bits};
    assign w_fr_in  = w_fr_ext[F-1:0];

    // clamp written maximum to [2, 2^D-1]
    always_comb begin
        w_cfg_den = i_cfg_data;
        if (w_cfg_den < CFG_W'(2)) begin
            w_cfg_den = CFG_W'(2);
        end else if (w_cfg_den > TOP16) begin
            w_cfg_den = TOP16;
        end
    end

    // mediant and its comparison terms
    assign w_med_n   = r_a + r_c;
    assign w_med_k   = r_b + r_d;
    assign w_med_p   = r_pb + r_pd;
    assign w_med_lhs = {w_med_n, {F{1'b0}}};
    assign w_in_loop = (r_b <= {1'b0, r_max}) && (r_d <= {1'b0, r_max});
    assign w_lhs1    = {r_n1, {F{1'b0}}};
    assign w_lhs2    = {r_n2, {F{1'b0}}};
    assign w_rel_lhs = w_lhs2;

    assign w_take     = r_ovalid && o_out.ready;
    assign w_load     = (r_state == S_DONE) && (!r_ovalid || o_out.ready);
    assign w_prod_ext = {{NUM_W{1'b0}}, w_prod};
    assign w_den_ext  = {{DEN_OUT_W{1'b0}}, r_k2};

    // operand select for the shared unit
    always_comb begin
        w_alu_ctl.start = 1'b0;
        w_alu_ctl.op    = ALU_MUL;
        w_alu_a         = '0;
        w_alu_b         = '0;
        case (r_state)
            S_CL_MUL1: begin
                w_alu_ctl.start = 1'b1;
                w_alu_a         = AW'(r_e1);
                w_alu_b         = r_k2;
            end
            S_CL_MUL2: begin
                w_alu_ctl.start = 1'b1;
                w_alu_a         = AW'(r_e2);
                w_alu_b         = r_k1;
            end
            S_M1_MUL: begin
                w_alu_ctl.start = 1'b1;
                w_alu_a         = AW'(r_fr);
                w_alu_b         = r_max;
            end
            S_M2_REM: begin
                w_alu_ctl.start = 1'b1;
                w_alu_ctl.op    = ALU_REM;
                w_alu_a         = AW'(r_max);
                w_alu_b         = r_i[D-1:0];
            end
            S_FOLD_MUL: begin
                w_alu_ctl.start = 1'b1;
                w_alu_a         = AW'(r_whole);
                w_alu_b         = r_k2;
            end
            default: begin
                w_alu_ctl.start = 1'b0;
            end
        endcase
    end

    bdf_alu #(.AW(AW), .DW(D)) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_alu_ctl),
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .o_sts   (w_alu_sts),
        .o_prod  (w_prod),
        .o_rem   (w_rem)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= D'(RST_DEN);
            r_mode   <= MODE_ANY;
            r_proper <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_DEN: r_max    <= D'(w_cfg_den);
                REG_MODE:    r_mode   <= i_cfg_data[1:0];
                REG_FORM:    r_proper <= i_cfg_data[0];
                default:     r_proper <= r_proper;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (w_take) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_neg   <= i_in.negative;
                        r_whole <= i_in.whole_part;
                        r_fr    <= w_fr_in;
                        r_zero  <= (i_in.whole_part == '0) && (w_fr_in == '0);
                        if (i_in.whole_part == '0 && w_fr_in == '0) begin
                            r_num   <= '0;
                            r_n2    <= '0;
                            r_k2    <= D'(1);
                            r_rel   <= REL_EQ;
                            r_state <= S_DONE;
                        end else if (r_mode == MODE_ANY) begin
                            r_a     <= '0;
                            r_b     <= KW'(1);
                            r_c     <= KW'(1);
                            r_d     <= KW'(1);
                            r_pb    <= PW'(w_fr_in);
                            r_pd    <= PW'(w_fr_in);
                            r_state <= S_M0_STEP;
                        end else if (r_mode == MODE_FIXED) begin
                            r_state <= S_M1_MUL;
                        end else begin
                            r_i     <= KW'(1);
                            r_pi    <= PW'(w_fr_in);
                            r_have  <= 1'b0;
                            r_state <= S_M2_REM;
                        end
                    end
                end
                // one Stern-Brocot step per cycle
                S_M0_STEP: begin
                    if (w_in_loop) begin
                        r_n1 <= r_c;
                        r_k1 <= r_d[D-1:0];
                        r_p1 <= r_pd;
                        if (w_med_lhs == w_med_p) begin
                            if (w_med_k <= {1'b0, r_max}) begin
                                r_n2 <= w_med_n;
                                r_k2 <= w_med_k[D-1:0];
                                r_p2 <= w_med_p;
                            end else if (r_d > r_b) begin
                                r_n2 <= r_c;
                                r_k2 <= r_d[D-1:0];
                                r_p2 <= r_pd;
                            end else begin
                                r_n2 <= r_a;
                                r_k2 <= r_b[D-1:0];
                                r_p2 <= r_pb;
                            end
                            r_state <= S_REL;
                        end else begin
                            r_n2 <= r_a;
                            r_k2 <= r_b[D-1:0];
                            r_p2 <= r_pb;
                            if (w_med_lhs < w_med_p) begin
                                r_a  <= w_med_n;
                                r_b  <= w_med_k;
                                r_pb <= w_med_p;
                            end else begin
                                r_c  <= w_med_n;
                                r_d  <= w_med_k;
                                r_pd <= w_med_p;
                            end
                        end
                    end else begin
                        r_state <= S_CL_ERR;
                    end
                end
                // absolute errors of both candidates, scaled by 2^F times their denominator
                S_CL_ERR: begin
                    r_e1    <= (r_p1 >= w_lhs1) ? r_p1 - w_lhs1 : w_lhs1 - r_p1;
                    r_e2    <= (r_p2 >= w_lhs2) ? r_p2 - w_lhs2 : w_lhs2 - r_p2;
                    r_state <= S_CL_MUL1;
                end
                S_CL_MUL1: r_state <= S_CL_WAIT1;
                S_CL_WAIT1: begin
                    if (w_alu_sts.done) begin
                        r_prod1 <= w_prod;
                        r_state <= S_CL_MUL2;
                    end
                end
                S_CL_MUL2: r_state <= S_CL_WAIT2;
                // candidate 1 strictly closer replaces candidate 2
                S_CL_WAIT2: begin
                    if (w_alu_sts.done) begin
                        if (r_prod1 < w_prod) begin
                            r_n2 <= r_n1;
                            r_k2 <= r_k1;
                            r_p2 <= r_p1;
                        end
                        r_state <= (r_mode == MODE_ANY) ? S_REL : S_M2_NEXT;
                    end
                end
                S_M1_MUL: r_state <= S_M1_WAIT;
                S_M1_WAIT: begin
                    if (w_alu_sts.done) begin
                        r_n2    <= f_round(w_prod[PW-1:0]);
                        r_k2    <= r_max;
                        r_p2    <= w_prod[PW-1:0];
                        r_state <= S_REL;
                    end
                end
                S_M2_REM: r_state <= S_M2_WAIT;
                // divisor found: first one is taken, later ones compared
                S_M2_WAIT: begin
                    if (w_alu_sts.done) begin
                        if (w_rem == '0) begin
                            r_n1 <= f_round(r_pi);
                            r_k1 <= r_i[D-1:0];
                            r_p1 <= r_pi;
                            if (!r_have) begin
                                r_have  <= 1'b1;
                                r_n2    <= f_round(r_pi);
                                r_k2    <= r_i[D-1:0];
                                r_p2    <= r_pi;
                                r_state <= S_M2_NEXT;
                            end else begin
                                r_state <= S_CL_ERR;
                            end
                        end else begin
                            r_state <= S_M2_NEXT;
                        end
                    end
                end
                S_M2_NEXT: begin
                    if (r_i == {1'b0, r_max}) begin
                        r_state <= S_REL;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_pi    <= r_pi + PW'(r_fr);
                        r_state <= S_M2_REM;
                    end
                end
                // compare chosen fraction with the value
                S_REL: begin
                    r_num <= NUM_W'(r_n2);
                    if (w_rel_lhs == r_p2) begin
                        r_rel <= REL_EQ;
                    end else if ((w_rel_lhs < r_p2) != r_neg) begin
                        r_rel <= REL_BELOW;
                    end else begin
                        r_rel <= REL_ABOVE;
                    end
                    r_state <= r_proper ? S_DONE : S_FOLD_MUL;
                end
                S_FOLD_MUL: r_state <= S_FOLD_WAIT;
                S_FOLD_WAIT: begin
                    if (w_alu_sts.done) begin
                        r_num   <= r_num + w_prod_ext[NUM_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_osign  <= r_zero ? SIGN_ZERO : (r_neg ? SIGN_NEG : SIGN_POS);
                        r_oint   <= (r_zero || !r_proper) ? '0 : r_whole;
                        r_onum   <= r_num;
                        r_oden   <= w_den_ext[DEN_OUT_W-1:0];
                        r_orel   <= r_rel;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.sign_code   = r_osign;
    assign o_out.integer_out = r_oint;
    assign o_out.numerator   = r_onum;
    assign o_out.denominator = r_oden;
    assign o_out.relation    = r_orel;

    `BDF_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready, "request taken while busy")
    `BDF_NEVER(a_den_nonzero, i_clk, i_rst_n, o_out.valid && (o_out.denominator == '0), "zero denominator")
    `BDF_NEVER(a_zero_result, i_clk, i_rst_n, o_out.valid && (o_out.sign_code == SIGN_ZERO) && (o_out.numerator != '0), "zero value with numerator")
    `BDF_NEVER(a_alu_overlap, i_clk, i_rst_n, w_alu_ctl.start && w_alu_sts.busy, "shared unit restarted")

endmodule
